@@ sv/fes_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Flash erase/program sequencer package
// Shared codes, constants and transaction types of the sequencer.
// ---------------------------------------------------------------------------
package fes_pkg;

    typedef enum logic [1:0] {
        OP_START_PROGRAM = 2'd0,
        OP_START_SECTOR  = 2'd1,
        OP_START_BANK    = 2'd2,
        OP_EVENT         = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_ERASE   = 2'd2,
        CMD_MASS    = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PROGRAM = 2'd1,
        ACT_SECTOR  = 2'd2,
        ACT_BANK    = 2'd3
    } activity_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BUSY        = 2'd1,
        ST_ARRAY_ERROR = 2'd2,
        ST_BANK_ABSENT = 2'd3
    } status_t;

    localparam logic CFG_ELEMENT_SIZE = 1'b0;
    localparam logic CFG_DUAL_BANK    = 1'b1;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    localparam logic [19:0] SMALL_REGION = 20'h10000;
    localparam logic [4:0]  BANK2_SECTOR = 5'd12;
    localparam logic [7:0]  KB_SMALL     = 8'd16;
    localparam logic [7:0]  KB_MID       = 8'd64;
    localparam logic [7:0]  KB_LARGE     = 8'd128;

    typedef struct packed {
        opcode_t      opcode;
        logic [20:0]  start_address;
        logic [15:0]  length;
        logic         bank_select;
        logic [31:0]  data_word;
        logic [5:0]   event_errors;
    } in_item_t;

    typedef struct packed {
        command_t     command;
        logic [20:0]  target_address;
        logic [4:0]   sector_number;
        logic [31:0]  write_data;
        status_t      status;
        logic         operation_done;
        logic [5:0]   error_flags;
    } result_t;

    typedef struct packed {
        logic         busy;
        activity_t    activity;
    } core_state_t;

endpackage : fes_pkg
`default_nettype wire

@@ sv/fes_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Sequencer core
// Holds the operation state and works out one result per registered item.
// ---------------------------------------------------------------------------
module fes_core #(
    parameter int FLASH_SIZE_KB = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [1:0]      cfg_data,
    input  wire logic            advance,
    input  wire fes_pkg::in_item_t item,
    output fes_pkg::result_t     result,
    output fes_pkg::core_state_t state
);
    import fes_pkg::*;

    localparam logic [20:0] HALF_BYTES  = 21'(FLASH_SIZE_KB * 512);
    localparam logic        BANK2_FIXED = (FLASH_SIZE_KB != 1024);

    typedef struct packed {
        logic [4:0] sector;
        logic [7:0] kb;
    } sector_map_t;

    logic [1:0]  element_size_code_reg;
    logic        dual_bank_reg;
    logic        busy_reg, busy_next;
    activity_t   act_reg, act_next;
    logic [20:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  kb_reg, kb_next;
    logic [5:0]  err_reg, err_next;

    logic        bank2;
    logic [1:0]  elem_shift;
    logic [15:0] count;
    logic [31:0] elem_data;
    sector_map_t map_start;
    sector_map_t map_cont;
    logic [20:0] cont_addr;

    function automatic sector_map_t map_sector(input logic [20:0] addr, input logic b2);
        sector_map_t m;
        logic [19:0] off;
        logic [20:0] diff;
        logic [4:0]  base;
        logic [2:0]  big;
        off  = addr[19:0];
        base = 5'd0;
        diff = addr - HALF_BYTES;
        if (b2 && (addr >= HALF_BYTES))
        begin
            base = BANK2_SECTOR;
            off  = diff[19:0];
        end
        big = off[19:17];
        if (off < SMALL_REGION)
        begin
            m.kb     = KB_SMALL;
            m.sector = base + {3'd0, off[15:14]};
        end
        else
        begin
            m.kb     = (big == 3'd0) ? KB_MID : KB_LARGE;
            m.sector = base + 5'd4 + {2'd0, big};
        end
        return m;
    endfunction

    assign bank2      = BANK2_FIXED || dual_bank_reg;
    assign elem_shift = (element_size_code_reg == 2'd3) ? 2'd2 : element_size_code_reg;
    assign count      = item.length >> elem_shift;
    assign cont_addr  = addr_reg + {3'd0, kb_reg, 10'd0};
    assign map_start  = map_sector(item.start_address, bank2);
    assign map_cont   = map_sector(cont_addr, bank2);

    always_comb
    begin
        case (elem_shift)
            2'd0:    elem_data = {24'd0, item.data_word[7:0]};
            2'd1:    elem_data = {16'd0, item.data_word[15:0]};
            default: elem_data = item.data_word;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        act_next  = act_reg;
        addr_next = addr_reg;
        rem_next  = rem_reg;
        kb_next   = kb_reg;
        err_next  = err_reg;
        result    = '0;
        result.command = CMD_NONE;
        result.status  = ST_OK;

        if ((item.opcode != OP_EVENT) && busy_reg)
        begin
            result.status = ST_BUSY;
        end
        else
        begin
            case (item.opcode)
                OP_START_PROGRAM:
                begin
                    addr_next = item.start_address;
                    if (count == 16'd0)
                    begin
                        busy_next = 1'b0;
                        act_next  = ACT_NONE;
                        rem_next  = 16'd0;
                        result.operation_done = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        act_next  = ACT_PROGRAM;
                        rem_next  = count - 16'd1;
                        result.command    = CMD_PROGRAM;
                        result.write_data = elem_data;
                    end
                end
                OP_START_SECTOR:
                begin
                    addr_next = item.start_address;
                    busy_next = 1'b1;
                    act_next  = ACT_SECTOR;
                    rem_next  = item.length;
                    kb_next   = map_start.kb;
                    result.sector_number = map_start.sector;
                    result.command       = CMD_ERASE;
                end
                OP_START_BANK:
                begin
                    if (item.bank_select && !bank2)
                    begin
                        result.status         = ST_BANK_ABSENT;
                        result.operation_done = 1'b1;
                    end
                    else
                    begin
                        addr_next = item.bank_select ? HALF_BYTES : 21'd0;
                        busy_next = 1'b1;
                        act_next  = ACT_BANK;
                        rem_next  = 16'd0;
                        result.command = CMD_MASS;
                    end
                end
                OP_EVENT:
                begin
                    if (busy_reg)
                    begin
                        err_next = item.event_errors;
                        if (item.event_errors != 6'd0)
                        begin
                            busy_next = 1'b0;
                            act_next  = ACT_NONE;
                            rem_next  = 16'd0;
                            result.status         = ST_ARRAY_ERROR;
                            result.operation_done = 1'b1;
                        end
                        else if ((act_reg == ACT_PROGRAM) && (rem_reg != 16'd0))
                        begin
                            addr_next = addr_reg + (21'd1 << elem_shift);
                            rem_next  = rem_reg - 16'd1;
                            result.command    = CMD_PROGRAM;
                            result.write_data = elem_data;
                        end
                        else if ((act_reg == ACT_SECTOR) && (rem_reg > {8'd0, kb_reg}))
                        begin
                            addr_next = cont_addr;
                            rem_next  = rem_reg - {8'd0, kb_reg};
                            kb_next   = map_cont.kb;
                            result.sector_number = map_cont.sector;
                            result.command       = CMD_ERASE;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                            act_next  = ACT_NONE;
                            rem_next  = 16'd0;
                            result.operation_done = 1'b1;
                        end
                    end
                end
                default:
                begin
                    result.status = ST_OK;
                end
            endcase
        end
        result.target_address = addr_next;
        result.error_flags    = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_size_code_reg <= 2'd2;
            dual_bank_reg         <= 1'b0;
            busy_reg              <= 1'b0;
            act_reg               <= ACT_NONE;
            addr_reg              <= 21'd0;
            rem_reg               <= 16'd0;
            kb_reg                <= 8'd0;
            err_reg               <= 6'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DUAL_BANK)
                begin
                    dual_bank_reg <= cfg_data[0];
                end
                else
                begin
                    element_size_code_reg <= cfg_data;
                end
            end
            if (advance)
            begin
                busy_reg <= busy_next;
                act_reg  <= act_next;
                addr_reg <= addr_next;
                rem_reg  <= rem_next;
                kb_reg   <= kb_next;
                err_reg  <= err_next;
            end
        end
    end

    assign state.busy     = busy_reg;
    assign state.activity = act_reg;

endmodule : fes_core
`default_nettype wire

@@ sv/flash_erase_program_sequencer_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Flash erase/program sequencer
// Turns start requests and array completion events into flash commands.
// ---------------------------------------------------------------------------
// Usage: each transaction on the s_axis channel is a start request (program,
// sector erase or bank mass erase) or a completion event from the flash array,
// selected by s_axis_tuser. Every input transaction produces exactly one
// result transaction on the m_axis channel, carrying the command for the array
// in m_axis_tuser; m_axis_tlast marks the result that ends or aborts an
// operation. A start request while an operation runs is answered with a busy
// status and no command. Configuration is written through cfg_we, cfg_index
// and cfg_data while no operation is in flight.
// A transaction passes through an input register and a result register, with
// the sequencing logic between them. Throughput is one transaction per cycle
// unless the receiver stalls; then the result register holds its transaction
// and the input register takes one more, after which s_axis_tready drops.
// Reset clears the operation state, the latched error flags and the valid
// flags of both registers; the element size resets to word.
// ---------------------------------------------------------------------------
module flash_erase_program_sequencer_top #(
    parameter int FLASH_SIZE_KB = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [1:0]                       cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // start_address, length, bank_select, data_word, event_errors, zero fill
    input  wire logic [fes_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode
    input  wire logic [1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // target_address, sector_number, write_data, status, error_flags, zero fill
    output logic [fes_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // command
    output logic [1:0]                            m_axis_tuser,
    // operation_done
    output logic                                  m_axis_tlast
);
    import fes_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    result_t     result;
    core_state_t core_state;
    logic        advance;
    in_item_t    in_item;

    assign in_item.opcode        = opcode_t'(s_axis_tuser);
    assign in_item.start_address = s_axis_tdata[20:0];
    assign in_item.length        = s_axis_tdata[36:21];
    assign in_item.bank_select   = s_axis_tdata[37];
    assign in_item.data_word     = s_axis_tdata[69:38];
    assign in_item.event_errors  = s_axis_tdata[75:70];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    fes_core #(
        .FLASH_SIZE_KB (FLASH_SIZE_KB)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (in_item_reg),
        .result    (result),
        .state     (core_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.command;
    assign m_axis_tlast  = out_res_reg.operation_done;
    assign m_axis_tdata  = {6'd0,
                            out_res_reg.error_flags,
                            out_res_reg.status,
                            out_res_reg.write_data,
                            out_res_reg.sector_number,
                            out_res_reg.target_address};

`ifndef NO_ASSERTIONS
    a_busy_matches_activity: assert property (@(posedge clk) disable iff (!rst_n)
        core_state.busy == (core_state.activity != ACT_NONE))
        else $error("busy flag disagrees with the active operation");

    a_reject_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.status == ST_BUSY)) |-> (out_res_reg.command == CMD_NONE))
        else $error("rejected start produced a command");

    a_done_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.operation_done) |-> (out_res_reg.command == CMD_NONE))
        else $error("final transaction of an operation carries a command");

    a_done_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.operation_done && (result.status != ST_BANK_ABSENT))
        |=> !core_state.busy)
        else $error("operation finished but the sequencer stayed busy");
`endif

endmodule : flash_erase_program_sequencer_top
`default_nettype wire
